[src/spo_pkg.sv]
package spo_pkg;

  // shape kind codes as carried in the input word
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  // control that travels down the pipe beside the geometry
  typedef struct packed {
    logic active;    // both shapes enabled
    logic use_dist;  // at least one circle: squared distance decides
    logic bb_hit;    // box against box interval result
  } spo_ctl_t;

endpackage

[src/spo_setup.sv]
module spo_setup import spo_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic                          a_kind,
  input  logic                          a_active,
  input  logic [COORD_BITS-1:0]         a_x,
  input  logic [COORD_BITS-1:0]         a_y,
  input  logic [COORD_BITS-1:0]         a_ext_x,
  input  logic [COORD_BITS-1:0]         a_ext_y,
  input  logic                          b_kind,
  input  logic                          b_active,
  input  logic [COORD_BITS-1:0]         b_x,
  input  logic [COORD_BITS-1:0]         b_y,
  input  logic [COORD_BITS-1:0]         b_ext_x,
  input  logic [COORD_BITS-1:0]         b_ext_y,
  output logic                          m_valid,
  input  logic                          m_ready,
  output spo_ctl_t                      m_ctl,
  output logic signed [COORD_BITS+1:0]  m_p_lox,
  output logic signed [COORD_BITS+1:0]  m_p_hix,
  output logic signed [COORD_BITS+1:0]  m_p_loy,
  output logic signed [COORD_BITS+1:0]  m_p_hiy,
  output logic signed [COORD_BITS+1:0]  m_q_lox,
  output logic signed [COORD_BITS+1:0]  m_q_hix,
  output logic signed [COORD_BITS+1:0]  m_q_loy,
  output logic signed [COORD_BITS+1:0]  m_q_hiy,
  output logic        [COORD_BITS+1:0]  m_r2
);

  localparam int PW = COORD_BITS + 2;

  logic                 valid_r;
  spo_ctl_t             ctl_r, ctl_nxt;
  logic signed [PW-1:0] a_cx, a_cy, a_wx, a_wy, b_cx, b_cy, b_wx, b_wy;
  logic signed [PW-1:0] a_lox, a_hix, a_loy, a_hiy, b_lox, b_hix, b_loy, b_hiy;
  logic signed [PW-1:0] p_lox_r, p_hix_r, p_loy_r, p_hiy_r, q_lox_r, q_hix_r, q_loy_r, q_hiy_r;
  logic signed [PW-1:0] p_lox_nxt, p_hix_nxt, p_loy_nxt, p_hiy_nxt;
  logic signed [PW-1:0] q_lox_nxt, q_hix_nxt, q_loy_nxt, q_hiy_nxt;
  logic [PW-2:0]        r_sum;
  logic [PW-1:0]        r2_r, r2_nxt;
  logic                 swap;

  assign s_ready = !valid_r || m_ready;

  // doubled centers and half extents at doubled scale
  always_comb begin
    a_cx = $signed({a_x[COORD_BITS-1], a_x, 1'b0});
    a_cy = $signed({a_y[COORD_BITS-1], a_y, 1'b0});
    b_cx = $signed({b_x[COORD_BITS-1], b_x, 1'b0});
    b_cy = $signed({b_y[COORD_BITS-1], b_y, 1'b0});
    a_wx = $signed({2'b00, a_ext_x});
    a_wy = $signed({2'b00, a_ext_y});
    b_wx = $signed({2'b00, b_ext_x});
    b_wy = $signed({2'b00, b_ext_y});
  end

  // a circle collapses to a point interval, a box spans its bounds
  always_comb begin
    a_lox = (a_kind == KIND_CIRCLE) ? a_cx : a_cx - a_wx;
    a_hix = (a_kind == KIND_CIRCLE) ? a_cx : a_cx + a_wx;
    a_loy = (a_kind == KIND_CIRCLE) ? a_cy : a_cy - a_wy;
    a_hiy = (a_kind == KIND_CIRCLE) ? a_cy : a_cy + a_wy;
    b_lox = (b_kind == KIND_CIRCLE) ? b_cx : b_cx - b_wx;
    b_hix = (b_kind == KIND_CIRCLE) ? b_cx : b_cx + b_wx;
    b_loy = (b_kind == KIND_CIRCLE) ? b_cy : b_cy - b_wy;
    b_hiy = (b_kind == KIND_CIRCLE) ? b_cy : b_cy + b_wy;
  end

  // role select: p is the box when kinds differ, q the circle
  always_comb begin
    swap = (a_kind == KIND_CIRCLE) && (b_kind == KIND_BOX);
    p_lox_nxt = swap ? b_lox : a_lox;
    p_hix_nxt = swap ? b_hix : a_hix;
    p_loy_nxt = swap ? b_loy : a_loy;
    p_hiy_nxt = swap ? b_hiy : a_hiy;
    q_lox_nxt = swap ? a_lox : b_lox;
    q_hix_nxt = swap ? a_hix : b_hix;
    q_loy_nxt = swap ? a_loy : b_loy;
    q_hiy_nxt = swap ? a_hiy : b_hiy;
    r_sum = ((a_kind == KIND_CIRCLE) ? {1'b0, a_ext_x} : '0)
          + ((b_kind == KIND_CIRCLE) ? {1'b0, b_ext_x} : '0);
    r2_nxt = {r_sum, 1'b0};
    ctl_nxt.active   = a_active && b_active;
    ctl_nxt.use_dist = (a_kind == KIND_CIRCLE) || (b_kind == KIND_CIRCLE);
    ctl_nxt.bb_hit   = 1'b0;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      ctl_r   <= ctl_nxt;
      p_lox_r <= p_lox_nxt;
      p_hix_r <= p_hix_nxt;
      p_loy_r <= p_loy_nxt;
      p_hiy_r <= p_hiy_nxt;
      q_lox_r <= q_lox_nxt;
      q_hix_r <= q_hix_nxt;
      q_loy_r <= q_loy_nxt;
      q_hiy_r <= q_hiy_nxt;
      r2_r    <= r2_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_ctl   = ctl_r;
  assign m_p_lox = p_lox_r;
  assign m_p_hix = p_hix_r;
  assign m_p_loy = p_loy_r;
  assign m_p_hiy = p_hiy_r;
  assign m_q_lox = q_lox_r;
  assign m_q_hix = q_hix_r;
  assign m_q_loy = q_loy_r;
  assign m_q_hiy = q_hiy_r;
  assign m_r2    = r2_r;

endmodule

[src/spo_offset.sv]
module spo_offset import spo_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  spo_ctl_t                      s_ctl,
  input  logic signed [COORD_BITS+1:0]  s_p_lox,
  input  logic signed [COORD_BITS+1:0]  s_p_hix,
  input  logic signed [COORD_BITS+1:0]  s_p_loy,
  input  logic signed [COORD_BITS+1:0]  s_p_hiy,
  input  logic signed [COORD_BITS+1:0]  s_q_lox,
  input  logic signed [COORD_BITS+1:0]  s_q_hix,
  input  logic signed [COORD_BITS+1:0]  s_q_loy,
  input  logic signed [COORD_BITS+1:0]  s_q_hiy,
  input  logic        [COORD_BITS+1:0]  s_r2,
  output logic                          m_valid,
  input  logic                          m_ready,
  output spo_ctl_t                      m_ctl,
  output logic        [COORD_BITS+1:0]  m_mag_x,
  output logic        [COORD_BITS+1:0]  m_mag_y,
  output logic        [COORD_BITS+1:0]  m_r2
);

  localparam int PW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 3;

  logic                 v2_r, v3_r, rdy2, rdy3;
  spo_ctl_t             ctl2_r, ctl2_nxt, ctl3_r;
  logic signed [DW-1:0] qx, qy, plx, phx, ply, phy;
  logic signed [DW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [DW-1:0] ax_full, ay_full;
  logic [PW-1:0]        r2a_r, r2b_r, magx_r, magy_r;

  assign rdy3    = !v3_r || m_ready;
  assign rdy2    = !v2_r || rdy3;
  assign s_ready = rdy2;

  // box overlap test and offset from circle center to its clamp point
  always_comb begin
    qx  = DW'(s_q_lox);
    qy  = DW'(s_q_loy);
    plx = DW'(s_p_lox);
    phx = DW'(s_p_hix);
    ply = DW'(s_p_loy);
    phy = DW'(s_p_hiy);
    ctl2_nxt        = s_ctl;
    ctl2_nxt.bb_hit = (s_p_lox <= s_q_hix) && (s_p_hix >= s_q_lox) &&
                      (s_p_loy <= s_q_hiy) && (s_p_hiy >= s_q_loy);
    priority if (qx < plx) begin
      dx_nxt = qx - plx;
    end else if (qx > phx) begin
      dx_nxt = qx - phx;
    end else begin
      dx_nxt = '0;
    end
    priority if (qy < ply) begin
      dy_nxt = qy - ply;
    end else if (qy > phy) begin
      dy_nxt = qy - phy;
    end else begin
      dy_nxt = '0;
    end
  end

  // magnitudes stay below four times the coordinate range
  always_comb begin
    ax_full = dx_r[DW-1] ? -dx_r : dx_r;
    ay_full = dy_r[DW-1] ? -dy_r : dy_r;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= s_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // offset stage payload
  always_ff @(posedge clk) begin
    if (s_valid && rdy2) begin
      ctl2_r <= ctl2_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      r2a_r  <= s_r2;
    end
  end

  // magnitude stage payload
  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      ctl3_r <= ctl2_r;
      magx_r <= ax_full[PW-1:0];
      magy_r <= ay_full[PW-1:0];
      r2b_r  <= r2a_r;
    end
  end

  assign m_valid = v3_r;
  assign m_ctl   = ctl3_r;
  assign m_mag_x = magx_r;
  assign m_mag_y = magy_r;
  assign m_r2    = r2b_r;

endmodule

[src/spo_dist.sv]
module spo_dist import spo_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  spo_ctl_t               s_ctl,
  input  logic [COORD_BITS+1:0]  s_mag_x,
  input  logic [COORD_BITS+1:0]  s_mag_y,
  input  logic [COORD_BITS+1:0]  s_r2,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic                   m_hit
);

  localparam int SW = 2 * (COORD_BITS + 2);

  logic          v4_r, v5_r, rdy4, rdy5;
  spo_ctl_t      ctl4_r;
  logic [SW-1:0] sqx_r, sqy_r, sqr_r;
  logic [SW:0]   dsum;
  logic          hit_r, hit_nxt;

  assign rdy5    = !v5_r || m_ready;
  assign rdy4    = !v4_r || rdy5;
  assign s_ready = rdy4;

  // sum of squares against squared reach, or the box result
  always_comb begin
    dsum    = {1'b0, sqx_r} + {1'b0, sqy_r};
    hit_nxt = ctl4_r.active &&
              (ctl4_r.use_dist ? (dsum <= {1'b0, sqr_r}) : ctl4_r.bb_hit);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= s_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  // squaring stage
  always_ff @(posedge clk) begin
    if (s_valid && rdy4) begin
      ctl4_r <= s_ctl;
      sqx_r  <= SW'(s_mag_x) * SW'(s_mag_x);
      sqy_r  <= SW'(s_mag_y) * SW'(s_mag_y);
      sqr_r  <= SW'(s_r2) * SW'(s_r2);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (v4_r && rdy5) begin
      hit_r <= hit_nxt;
    end
  end

  assign m_valid = v5_r;
  assign m_hit   = hit_r;

endmodule

[src/shape_pair_overlap_test.sv]
// Shape pair overlap test: one pair of 2D shapes (box or circle) per input
// word, one hit flag per output word.
// Input channel: in_tdata carries the eight coordinate fields, COORD_BITS
// each, in_tuser the kind and active flags of both shapes. Coordinates are
// signed fixed point (Q12.4 at the default width), extents unsigned.
// Output channel: out_tdata bit 0 is the hit flag, set when both shapes are
// active and touch or overlap; edge contact counts as a hit.
// Throughput: one word per cycle while out_tready stays high. The five register
// stages lie between acceptance and out_tvalid: role select, clamp offset,
// magnitude, squaring, compare/output register.
// Reset (rst_n low, synchronous) empties the pipe; there is no other state.
// When the receiver holds out_tready low, words stay in their stages and
// in_tready drops once every stage is full; nothing is lost or repeated.
// in_tready depends combinationally on out_tready through the stage chain.
module shape_pair_overlap_test import spo_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // a_x, a_y, a_ext_x, a_ext_y, b_x, b_y, b_ext_x, b_ext_y
  input  logic [8*COORD_BITS-1:0] in_tdata,
  // a_kind, a_active, b_kind, b_active
  input  logic [3:0]              in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // hit, zero fill above
  output logic [7:0]              out_tdata
);

  localparam int CB = COORD_BITS;
  localparam int PW = COORD_BITS + 2;

  logic                 v1, r1, v3, r3;
  spo_ctl_t             ctl1, ctl3;
  logic signed [PW-1:0] p_lox, p_hix, p_loy, p_hiy, q_lox, q_hix, q_loy, q_hiy;
  logic [PW-1:0]        r2_1, r2_3, mag_x, mag_y;
  logic                 hit;

  // role selection and doubled bounds
  spo_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (in_tvalid),
    .s_ready  (in_tready),
    .a_kind   (in_tuser[0]),
    .a_active (in_tuser[1]),
    .a_x      (in_tdata[0*CB +: CB]),
    .a_y      (in_tdata[1*CB +: CB]),
    .a_ext_x  (in_tdata[2*CB +: CB]),
    .a_ext_y  (in_tdata[3*CB +: CB]),
    .b_kind   (in_tuser[2]),
    .b_active (in_tuser[3]),
    .b_x      (in_tdata[4*CB +: CB]),
    .b_y      (in_tdata[5*CB +: CB]),
    .b_ext_x  (in_tdata[6*CB +: CB]),
    .b_ext_y  (in_tdata[7*CB +: CB]),
    .m_valid  (v1),
    .m_ready  (r1),
    .m_ctl    (ctl1),
    .m_p_lox  (p_lox),
    .m_p_hix  (p_hix),
    .m_p_loy  (p_loy),
    .m_p_hiy  (p_hiy),
    .m_q_lox  (q_lox),
    .m_q_hix  (q_hix),
    .m_q_loy  (q_loy),
    .m_q_hiy  (q_hiy),
    .m_r2     (r2_1)
  );

  // interval test, clamp offset and magnitude
  spo_offset #(.COORD_BITS(COORD_BITS)) u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v1),
    .s_ready (r1),
    .s_ctl   (ctl1),
    .s_p_lox (p_lox),
    .s_p_hix (p_hix),
    .s_p_loy (p_loy),
    .s_p_hiy (p_hiy),
    .s_q_lox (q_lox),
    .s_q_hix (q_hix),
    .s_q_loy (q_loy),
    .s_q_hiy (q_hiy),
    .s_r2    (r2_1),
    .m_valid (v3),
    .m_ready (r3),
    .m_ctl   (ctl3),
    .m_mag_x (mag_x),
    .m_mag_y (mag_y),
    .m_r2    (r2_3)
  );

  // squares, compare and output register
  spo_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v3),
    .s_ready (r3),
    .s_ctl   (ctl3),
    .s_mag_x (mag_x),
    .s_mag_y (mag_y),
    .s_r2    (r2_3),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_hit   (hit)
  );

  assign out_tdata = {7'b0000000, hit};

endmodule

[tb/shape_pair_overlap_test_tb.sv]
module shape_pair_overlap_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spo_pkg::*;

  localparam int CW       = 16;
  localparam int N_RANDOM = 1500;
  localparam int LATENCY  = 5;

  // one shape pair as carried by an input word
  typedef struct {
    logic              a_kind;
    logic              a_active;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic [CW-1:0]     a_ext_x;
    logic [CW-1:0]     a_ext_y;
    logic              b_kind;
    logic              b_active;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic [CW-1:0]     b_ext_x;
    logic [CW-1:0]     b_ext_y;
  } shape_pair_t;

  typedef struct {
    shape_pair_t pair;
    logic        hit;
  } pending_hit_t;

  // expected hit flags in acceptance order, plus the geometry that predicts them
  class pair_scoreboard;
    pending_hit_t hits_due[$];
    int errors;
    int words_in;
    int words_out;
    int n_box_box;
    int n_circ_circ;
    int n_mixed;
    int n_inactive;
    int n_hits;

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    // squared distance against squared reach, exact in 64 bits at these widths
    function logic within_radius(longint dx, longint dy, longint r);
      return (dx * dx + dy * dy) <= (r * r);
    endfunction

    // all box tests run at doubled scale so half sizes stay exact
    function logic boxes_touch(longint ax, longint ay, longint aw, longint ah,
                               longint bx, longint by, longint bw, longint bh);
      return (2 * ax - aw <= 2 * bx + bw) && (2 * ax + aw >= 2 * bx - bw) &&
             (2 * ay - ah <= 2 * by + bh) && (2 * ay + ah >= 2 * by - bh);
    endfunction

    function logic box_meets_circle(longint bx, longint by, longint bw, longint bh,
                                    longint cx, longint cy, longint r);
      longint px;
      longint py;
      px = clamp(2 * cx, 2 * bx - bw, 2 * bx + bw);
      py = clamp(2 * cy, 2 * by - bh, 2 * by + bh);
      return within_radius(2 * cx - px, 2 * cy - py, 2 * r);
    endfunction

    function logic predict_hit(shape_pair_t p);
      longint ax;
      longint ay;
      longint aw;
      longint ah;
      longint bx;
      longint by;
      longint bw;
      longint bh;
      ax = longint'(p.a_x);
      ay = longint'(p.a_y);
      aw = longint'(p.a_ext_x);
      ah = longint'(p.a_ext_y);
      bx = longint'(p.b_x);
      by = longint'(p.b_y);
      bw = longint'(p.b_ext_x);
      bh = longint'(p.b_ext_y);
      if (!p.a_active || !p.b_active) return 1'b0;
      if (p.a_kind == KIND_BOX && p.b_kind == KIND_BOX)
        return boxes_touch(ax, ay, aw, ah, bx, by, bw, bh);
      if (p.a_kind == KIND_CIRCLE && p.b_kind == KIND_CIRCLE)
        return within_radius(ax - bx, ay - by, aw + bw);
      if (p.a_kind == KIND_BOX)
        return box_meets_circle(ax, ay, aw, ah, bx, by, bw);
      return box_meets_circle(bx, by, bw, bh, ax, ay, aw);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    function void note_pair(shape_pair_t p);
      pending_hit_t e;
      e.pair = p;
      e.hit  = predict_hit(p);
      hits_due.push_back(e);
      words_in++;
      if (!p.a_active || !p.b_active) n_inactive++;
      if (p.a_kind == KIND_BOX && p.b_kind == KIND_BOX) n_box_box++;
      else if (p.a_kind == KIND_CIRCLE && p.b_kind == KIND_CIRCLE) n_circ_circ++;
      else n_mixed++;
      if (e.hit) n_hits++;
    endfunction

    task check_result(logic [7:0] word);
      pending_hit_t e;
      words_out++;
      if (hits_due.size() == 0) begin
        report_mismatch($sformatf("result word %02h with no pair pending", word));
      end else begin
        e = hits_due.pop_front();
        if (word[0] !== e.hit)
          report_mismatch($sformatf(
            "hit %b expected %b: kinds %b/%b act %b/%b a(%0d,%0d %0d,%0d) b(%0d,%0d %0d,%0d)",
            word[0], e.hit, e.pair.a_kind, e.pair.b_kind, e.pair.a_active,
            e.pair.b_active, e.pair.a_x, e.pair.a_y, e.pair.a_ext_x, e.pair.a_ext_y,
            e.pair.b_x, e.pair.b_y, e.pair.b_ext_x, e.pair.b_ext_y));
        if (word[7:1] !== 7'd0)
          report_mismatch($sformatf("fill bits of result word not zero: %02h", word));
      end
    endtask

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [8*CW-1:0]   in_tdata = '0;
  logic [3:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;

  pair_scoreboard sb = new();
  bit pressure_done = 1'b0;

  shape_pair_overlap_test #(.COORD_BITS(CW)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // a_x, a_y, a_ext_x, a_ext_y, b_x, b_y, b_ext_x, b_ext_y
    .in_tuser   (in_tuser),   // a_kind, a_active, b_kind, b_active
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // hit, zero fill above
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // both sides run without gaps over this stretch of accepted words
  function bit calm_stretch();
    return sb.words_in >= 700 && sb.words_in < 1000;
  endfunction

  function shape_pair_t make_pair(logic ak, logic aa, int ax, int ay, int aw, int ah,
                                  logic bk, logic ba, int bx, int by, int bw, int bh);
    shape_pair_t p;
    p.a_kind = ak;   p.a_active = aa;
    p.a_x = CW'(ax); p.a_y = CW'(ay); p.a_ext_x = CW'(aw); p.a_ext_y = CW'(ah);
    p.b_kind = bk;   p.b_active = ba;
    p.b_x = CW'(bx); p.b_y = CW'(by); p.b_ext_x = CW'(bw); p.b_ext_y = CW'(bh);
    return p;
  endfunction

  function logic rand_kind();
    return $urandom_range(0, 1) ? KIND_CIRCLE : KIND_BOX;
  endfunction

  // mostly nearby active pairs, some built to touch exactly, some pure noise
  function shape_pair_t rand_pair();
    shape_pair_t p;
    int mode;
    int ax;
    int ay;
    int k;
    int ra;
    int wa;
    int wb;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      p.a_kind = rand_kind();  p.a_active = 1'($urandom_range(0, 1));
      p.b_kind = rand_kind();  p.b_active = 1'($urandom_range(0, 1));
      p.a_x = CW'($urandom); p.a_y = CW'($urandom);
      p.a_ext_x = CW'($urandom); p.a_ext_y = CW'($urandom);
      p.b_x = CW'($urandom); p.b_y = CW'($urandom);
      p.b_ext_x = CW'($urandom); p.b_ext_y = CW'($urandom);
    end else if (mode == 1) begin
      ax = int'($urandom_range(0, 40000)) - 20000;
      ay = int'($urandom_range(0, 40000)) - 20000;
      if ($urandom_range(0, 1)) begin
        // boxes meeting edge to edge along x
        wa = 2 * int'($urandom_range(0, 300));
        wb = 2 * int'($urandom_range(0, 300));
        p = make_pair(KIND_BOX, 1'b1, ax, ay, wa, $urandom_range(0, 600),
                      KIND_BOX, 1'b1, ax + (wa + wb) / 2, ay + int'($urandom_range(0, 20)),
                      wb, $urandom_range(40, 600));
      end else begin
        // circles on a 3-4-5 triangle with radii summing to the distance
        k  = $urandom_range(1, 300);
        ra = $urandom_range(0, 5 * k);
        p = make_pair(KIND_CIRCLE, 1'b1, ax, ay, ra, $urandom,
                      KIND_CIRCLE, 1'b1, ax + ($urandom_range(0, 1) ? 3 * k : -3 * k),
                      ay + ($urandom_range(0, 1) ? 4 * k : -4 * k), 5 * k - ra, $urandom);
      end
    end else begin
      p.a_kind = rand_kind();  p.a_active = ($urandom_range(0, 99) >= 5);
      p.b_kind = rand_kind();  p.b_active = ($urandom_range(0, 99) >= 5);
      p.a_x = CW'($urandom); p.a_y = CW'($urandom);
      p.b_x = CW'(int'(p.a_x) + int'($urandom_range(0, 1200)) - 600);
      p.b_y = CW'(int'(p.a_y) + int'($urandom_range(0, 1200)) - 600);
      if (mode == 9) begin
        p.a_ext_x = CW'($urandom); p.a_ext_y = CW'($urandom);
        p.b_ext_x = CW'($urandom); p.b_ext_y = CW'($urandom);
      end else begin
        p.a_ext_x = CW'($urandom_range(0, 700)); p.a_ext_y = CW'($urandom_range(0, 700));
        p.b_ext_x = CW'($urandom_range(0, 700)); p.b_ext_y = CW'($urandom_range(0, 700));
      end
    end
    return p;
  endfunction

  // offer one word, possibly after a short gap, and wait until it is taken
  task automatic send_pair(shape_pair_t p);
    int gap;
    gap = 0;
    if (!calm_stretch() && $urandom_range(0, 99) < 2) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.b_ext_y, p.b_ext_x, p.b_y, p.b_x, p.a_ext_y, p.a_ext_x, p.a_y, p.a_x};
    in_tuser  <= {p.b_active, p.b_kind, p.a_active, p.a_kind};
    do @(posedge clk); while (!in_tready);
    sb.note_pair(p);
  endtask

  // receiver: random stalls, one long hold-off so the pipe backs up
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (!pressure_done && sb.words_in >= 400) begin
        out_tready <= 1'b0;
        for (held = 1; held < 80; held++) @(posedge clk);
        pressure_done = 1'b1;
      end else if (calm_stretch()) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin : stimulus
    shape_pair_t directed[$];
    int i;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // inactive shapes never hit, even when fully overlapping
    directed.push_back(make_pair(KIND_BOX, 1'b0, 0, 0, 64, 64, KIND_BOX, 1'b1, 0, 0, 64, 64));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 0, 0, 64, 0, KIND_BOX, 1'b0, 0, 0, 64, 64));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b0, 0, 0, 64, 0, KIND_CIRCLE, 1'b0, 0, 0, 64, 0));
    // boxes touching at an edge, then one step apart
    directed.push_back(make_pair(KIND_BOX, 1'b1, 0, 0, 32, 32, KIND_BOX, 1'b1, 32, 0, 32, 32));
    directed.push_back(make_pair(KIND_BOX, 1'b1, 0, 0, 32, 32, KIND_BOX, 1'b1, 33, 0, 32, 32));
    directed.push_back(make_pair(KIND_BOX, 1'b1, 0, 0, 32, 32, KIND_BOX, 1'b1, 0, -33, 32, 32));
    // circles touching exactly, then just apart
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 0, 0, 20, 0, KIND_CIRCLE, 1'b1, 30, 40, 30, 0));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 0, 0, 20, 0, KIND_CIRCLE, 1'b1, 30, 40, 29, 0));
    // circle touching a box corner, missing it, and the same with roles swapped
    directed.push_back(make_pair(KIND_BOX, 1'b1, 0, 0, 20, 20, KIND_CIRCLE, 1'b1, 13, 14, 5, 0));
    directed.push_back(make_pair(KIND_BOX, 1'b1, 0, 0, 20, 20, KIND_CIRCLE, 1'b1, 13, 14, 4, 0));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 13, 14, 5, 0, KIND_BOX, 1'b1, 0, 0, 20, 20));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 13, 14, 4, 0, KIND_BOX, 1'b1, 0, 0, 20, 20));
    // circle centre inside a box
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 3, -2, 1, 0, KIND_BOX, 1'b1, 0, 0, 40, 40));
    // zero extents: points meet only when coincident
    directed.push_back(make_pair(KIND_BOX, 1'b1, 5, -5, 0, 0, KIND_BOX, 1'b1, 5, -5, 0, 0));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 5, -5, 0, 0, KIND_BOX, 1'b1, 5, -5, 0, 0));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 5, -5, 0, 0, KIND_CIRCLE, 1'b1, 5, -4, 0, 0));
    directed.push_back(make_pair(KIND_BOX, 1'b1, 5, -5, 0, 0, KIND_CIRCLE, 1'b1, 6, -5, 0, 0));
    // extremes of coordinates and extents
    directed.push_back(make_pair(KIND_BOX, 1'b1, -32768, -32768, 65535, 65535,
                                 KIND_BOX, 1'b1, 32767, 32767, 65535, 65535));
    directed.push_back(make_pair(KIND_BOX, 1'b1, -32768, -32768, 65534, 65535,
                                 KIND_BOX, 1'b1, 32767, 32767, 65535, 65535));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, -32768, -32768, 65535, 65535,
                                 KIND_CIRCLE, 1'b1, 32767, 32767, 65535, 65535));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, -32768, 32767, 0, 65535,
                                 KIND_CIRCLE, 1'b1, 32767, -32768, 0, 0));
    directed.push_back(make_pair(KIND_BOX, 1'b1, -32768, 32767, 65535, 65535,
                                 KIND_CIRCLE, 1'b1, 32767, -32768, 65535, 0));
    directed.push_back(make_pair(KIND_CIRCLE, 1'b1, 32767, 32767, 0, 0,
                                 KIND_BOX, 1'b1, -32768, -32768, 0, 0));

    foreach (directed[j]) send_pair(directed[j]);
    for (i = 0; i < N_RANDOM; i++) send_pair(rand_pair());
    in_tvalid <= 1'b0;

    // drain, then give the pipe time to show any stray word
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("covered %0d pairs: %0d box/box, %0d circle/circle, %0d mixed, %0d inactive",
             sb.words_in, sb.n_box_box, sb.n_circ_circ, sb.n_mixed, sb.n_inactive);
    $display("%0d hits predicted, %0d result words checked, receiver hold-off %s",
             sb.n_hits, sb.words_out, pressure_done ? "applied" : "not reached");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
